### src/mru_tag_cache_with_prefetch_slot_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the move-to-front tag cache
// Concurrent check wrappers; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MRU_TAG_CACHE_WITH_PREFETCH_SLOT_CORE_MACROS_SVH
`define MRU_TAG_CACHE_WITH_PREFETCH_SLOT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MTC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mtc check failed: same-cycle implication");
// next-cycle implication
`define MTC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mtc check failed: next-cycle implication");
`else
`define MTC_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define MTC_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif

`endif

### src/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared constants for the move-to-front tag cache: defaults, widths and
// configuration register indexes.
// ----------------------------------------------------------------------------
package mtc_pkg;

	// default geometry
	localparam int MAX_ENTRIES_DEF = 16;
	localparam int TAG_BITS_DEF    = 32;

	// fixed field widths
	localparam int IN_TAG_BITS   = 32;
	localparam int OUT_SLOT_BITS = 4;
	localparam int OUT_DATA_BITS = 8;
	localparam int EXTRA_BITS    = 4;
	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;

	// register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_EXTRA    = 2'd0;
	localparam logic [1:0] REG_PREFETCH = 2'd1;
	localparam logic [1:0] REG_INVALID  = 2'd2;

endpackage

### src/mru_tag_cache_with_prefetch_slot_core.sv
// ----------------------------------------------------------------------------
// mru_tag_cache_with_prefetch_slot_core
// Move-to-front tag cache with a prefetch position, built as a ring of
// entry cells that rotates past a single compare point at the head.
// ----------------------------------------------------------------------------
// Sequence: a request is searched over the whole ring and the list rebuilt;
//   a miss that takes a free slot adds a scan of the used mask, and a
//   prefetch while prefetch is disabled goes straight to the result.
// Throughput: one request at a time; set by the ring rotation (one pass to
//   search, one pass to rebuild, plus a free-slot scan of the used mask).
// Reset: list length and control clear at once; cell contents stay unknown.
// ----------------------------------------------------------------------------
`include "mru_tag_cache_with_prefetch_slot_core_macros.svh"

module mru_tag_cache_with_prefetch_slot_core #(
	parameter int MAX_ENTRIES = mtc_pkg::MAX_ENTRIES_DEF,
	parameter int TAG_BITS    = mtc_pkg::TAG_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mtc_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [mtc_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [mtc_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                              pready,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mtc_pkg::IN_TAG_BITS-1:0]   s_tdata,  // [31:0] tag
	input  logic                              s_tuser,  // [0] func
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] hit, [4:1] slot, [5] start_load, [6] ready_now, [7] ignored
	output logic [mtc_pkg::OUT_DATA_BITS-1:0] m_tdata
);

	localparam int SLOT_BITS = $clog2(MAX_ENTRIES);
	localparam int LEN_BITS  = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_BITS  = (LEN_BITS > 5) ? LEN_BITS : 5;
	localparam logic [SLOT_BITS-1:0] CNT_LAST = SLOT_BITS'(MAX_ENTRIES - 1);
	localparam logic [LEN_BITS-1:0]  POS_NONE = LEN_BITS'(MAX_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SCAN,
		ST_BUILD,
		ST_EMIT
	} state_t;

	// configuration registers
	logic [mtc_pkg::EXTRA_BITS-1:0]  extra_q;
	logic                            pe_q;
	logic [mtc_pkg::IN_TAG_BITS-1:0] inv_q;

	// control and working registers
	state_t                state_q;
	logic [SLOT_BITS-1:0]  cnt_q;
	logic [LEN_BITS-1:0]   len_q;
	logic [LEN_BITS-1:0]   r_q;
	logic                  found_q;
	logic                  func_q;
	logic                  ins_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [SLOT_BITS-1:0]  e_slot_q;
	logic [SLOT_BITS-1:0]  reuse_q;
	logic [MAX_ENTRIES-1:0] used_q;
	logic [SLOT_BITS-1:0]  prev_slot_q;
	logic [TAG_BITS-1:0]   prev_tag_q;
	logic                  res_hit_q;
	logic                  res_start_q;
	logic                  res_ready_q;
	logic                  res_ign_q;
	logic                  m_tvalid_q;
	logic [mtc_pkg::OUT_DATA_BITS-1:0] m_tdata_q;

	// ring of cells
	logic [SLOT_BITS-1:0] cell_slot [MAX_ENTRIES];
	logic [TAG_BITS-1:0]  cell_tag  [MAX_ENTRIES];
	logic [SLOT_BITS-1:0] nxt_slot  [MAX_ENTRIES];
	logic [TAG_BITS-1:0]  nxt_tag   [MAX_ENTRIES];
	logic [SLOT_BITS-1:0] tail_slot;
	logic [TAG_BITS-1:0]  tail_tag;
	logic                 shift_en;

	// derived values
	logic [TAG_BITS+mtc_pkg::IN_TAG_BITS-1:0] req_ext;
	logic [TAG_BITS+mtc_pkg::IN_TAG_BITS-1:0] inv_ext;
	logic [TAG_BITS-1:0]  req_tag;
	logic [TAG_BITS-1:0]  inv_tag;
	logic [CAP_BITS-1:0]  cap_raw;
	logic [LEN_BITS-1:0]  cap_w;
	logic [LEN_BITS-1:0]  len_cut;
	logic [LEN_BITS-1:0]  cnt_pos;
	logic                 head_hit;
	logic [SLOT_BITS+mtc_pkg::OUT_SLOT_BITS-1:0] slot_ext;
	logic                 cfg_wr;
	logic [3:0]           out_flags;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extra_q <= '0;
			pe_q    <= 1'b0;
			inv_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mtc_pkg::REG_EXTRA:    extra_q <= pwdata[mtc_pkg::EXTRA_BITS-1:0];
				mtc_pkg::REG_PREFETCH: pe_q    <= pwdata[0];
				mtc_pkg::REG_INVALID:  inv_q   <= pwdata[mtc_pkg::IN_TAG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			mtc_pkg::REG_EXTRA:    prdata = {{(mtc_pkg::CFG_DATA_BITS-mtc_pkg::EXTRA_BITS){1'b0}},
			                                 extra_q};
			mtc_pkg::REG_PREFETCH: prdata = {{(mtc_pkg::CFG_DATA_BITS-1){1'b0}}, pe_q};
			mtc_pkg::REG_INVALID:  prdata = inv_q;
			default:               prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// tags masked to TAG_BITS, capacity and cut length
	// ------------------------------------------------------------------
	assign req_ext = {{TAG_BITS{1'b0}}, s_tdata};
	assign inv_ext = {{TAG_BITS{1'b0}}, inv_q};
	assign req_tag = req_ext[TAG_BITS-1:0];
	assign inv_tag = inv_ext[TAG_BITS-1:0];

	assign cap_raw = CAP_BITS'(extra_q) + CAP_BITS'(pe_q) + CAP_BITS'(1);
	assign cap_w   = (cap_raw > CAP_BITS'(MAX_ENTRIES)) ? POS_NONE : cap_raw[LEN_BITS-1:0];
	assign len_cut = (len_q > cap_w) ? cap_w : len_q;

	assign cnt_pos  = LEN_BITS'(cnt_q);
	assign head_hit = !found_q && (cnt_pos < len_q) && (cell_tag[0] == tag_q);

	// ------------------------------------------------------------------
	// cell chain; the tail is fed by the head (rotate) or the rebuild mux
	// ------------------------------------------------------------------
	assign shift_en = (state_q == ST_SEARCH) || (state_q == ST_BUILD);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign nxt_slot[i] = tail_slot;
			assign nxt_tag[i]  = tail_tag;
		end else begin : g_link
			assign nxt_slot[i] = cell_slot[i+1];
			assign nxt_tag[i]  = cell_tag[i+1];
		end

		mtc_cell #(
			.SLOT_BITS(SLOT_BITS),
			.TAG_BITS (TAG_BITS)
		) u_cell (
			.clk    (clk),
			.shift  (shift_en),
			.in_slot(nxt_slot[i]),
			.in_tag (nxt_tag[i]),
			.slot   (cell_slot[i]),
			.tag    (cell_tag[i])
		);
	end

	// rebuild: new list = old list with r removed, entry inserted at ins.
	// head holds old[c], cell 1 old[c+1], prev register old[c-1]
	always_comb begin
		tail_slot = cell_slot[0];
		tail_tag  = cell_tag[0];
		if (state_q == ST_BUILD) begin
			if (ins_q && (cnt_q == '0)) begin
				// ahead of the insert point
				if (cnt_pos >= r_q) begin
					tail_slot = cell_slot[1];
					tail_tag  = cell_tag[1];
				end
			end else if (cnt_pos == LEN_BITS'(ins_q)) begin
				tail_slot = e_slot_q;
				tail_tag  = tag_q;
			end else if ((cnt_pos - LEN_BITS'(1)) < r_q) begin
				tail_slot = prev_slot_q;
				tail_tag  = prev_tag_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	assign slot_ext = {{mtc_pkg::OUT_SLOT_BITS{1'b0}}, e_slot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			len_q       <= '0;
			r_q         <= POS_NONE;
			found_q     <= 1'b0;
			func_q      <= 1'b0;
			ins_q       <= 1'b0;
			tag_q       <= '0;
			e_slot_q    <= '0;
			reuse_q     <= '0;
			used_q      <= '0;
			prev_slot_q <= '0;
			prev_tag_q  <= '0;
			res_hit_q   <= 1'b0;
			res_start_q <= 1'b0;
			res_ready_q <= 1'b0;
			res_ign_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// result valid: set when emitted, cleared once taken downstream
			if ((state_q == ST_EMIT) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						len_q       <= len_cut;
						cnt_q       <= '0;
						r_q         <= POS_NONE;
						found_q     <= 1'b0;
						func_q      <= s_tuser;
						tag_q       <= req_tag;
						e_slot_q    <= '0;
						used_q      <= '0;
						res_hit_q   <= 1'b0;
						res_start_q <= 1'b0;
						res_ready_q <= 1'b0;
						res_ign_q   <= s_tuser & ~pe_q;
						if (s_tuser && !pe_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end

				// one position per cycle passes the head compare
				ST_SEARCH: begin
					if (cnt_pos < len_q) begin
						used_q[cell_slot[0]] <= 1'b1;
					end
					if (head_hit) begin
						found_q  <= 1'b1;
						r_q      <= cnt_pos;
						e_slot_q <= cell_slot[0];
					end
					if (cnt_pos == cap_w - LEN_BITS'(1)) begin
						reuse_q <= cell_slot[0];
					end
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DECIDE;
					end else begin
						cnt_q <= cnt_q + SLOT_BITS'(1);
					end
				end

				ST_DECIDE: begin
					if (found_q) begin
						res_hit_q <= 1'b1;
						ins_q     <= func_q && (len_q > LEN_BITS'(1));
						state_q   <= ST_BUILD;
					end else begin
						res_ready_q <= (tag_q == inv_tag);
						res_start_q <= (tag_q != inv_tag);
						if (len_q < cap_w) begin
							len_q   <= len_q + LEN_BITS'(1);
							ins_q   <= func_q && (len_q != '0);
							state_q <= ST_SCAN;
						end else begin
							r_q      <= cap_w - LEN_BITS'(1);
							e_slot_q <= reuse_q;
							ins_q    <= func_q && (cap_w > LEN_BITS'(1));
							state_q  <= ST_BUILD;
						end
					end
				end

				// lowest free slot: walk the used mask one bit a cycle
				ST_SCAN: begin
					if (!used_q[0]) begin
						e_slot_q <= cnt_q;
						cnt_q    <= '0;
						state_q  <= ST_BUILD;
					end else begin
						used_q <= used_q >> 1;
						cnt_q  <= cnt_q + SLOT_BITS'(1);
					end
				end

				ST_BUILD: begin
					prev_slot_q <= cell_slot[0];
					prev_tag_q  <= cell_tag[0];
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + SLOT_BITS'(1);
					end
				end

				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {res_ign_q, res_ready_q, res_start_q,
						               slot_ext[mtc_pkg::OUT_SLOT_BITS-1:0], res_hit_q};
						state_q    <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	assign out_flags = {m_tdata[7:5], m_tdata[0]};

	`MTC_ASSERT_IMP(a_len_in_cap, clk, arst_n, state_q == ST_SEARCH, len_q <= cap_w)
	`MTC_ASSERT_IMP(a_one_outcome, clk, arst_n, m_tvalid, $onehot(out_flags))
	`MTC_ASSERT_IMP(a_build_nonempty, clk, arst_n, state_q == ST_BUILD, len_q != '0)
	`MTC_ASSERT_NXT(a_emit_waits, clk, arst_n,
		(state_q == ST_EMIT) && m_tvalid && !m_tready, state_q == ST_EMIT)

endmodule

### src/mtc_cell.sv
// ----------------------------------------------------------------------------
// mtc_cell
// One list position of the tag cache: holds a slot number and its tag and
// takes its neighbor's entry whenever the chain shifts.
// ----------------------------------------------------------------------------
module mtc_cell #(
	parameter int SLOT_BITS = $clog2(mtc_pkg::MAX_ENTRIES_DEF),
	parameter int TAG_BITS  = mtc_pkg::TAG_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 shift,
	input  logic [SLOT_BITS-1:0] in_slot,
	input  logic [TAG_BITS-1:0]  in_tag,
	output logic [SLOT_BITS-1:0] slot,
	output logic [TAG_BITS-1:0]  tag
);

	logic [SLOT_BITS-1:0] slot_q;
	logic [TAG_BITS-1:0]  tag_q;

	// entry register, loaded from the neighbor on shift
	always_ff @(posedge clk) begin
		if (shift) begin
			slot_q <= in_slot;
			tag_q  <= in_tag;
		end
	end

	assign slot = slot_q;
	assign tag  = tag_q;

endmodule

### dv/mru_tag_cache_with_prefetch_slot_core_tb.sv
// ----------------------------------------------------------------------------
// mru_tag_cache_with_prefetch_slot_core_tb
// Self-checking bench for the move-to-front tag cache. Requests stream in on
// the slave side and are mirrored by a cycle-free list model. Each result on
// the master side is checked field by field against the oldest prediction.
// The run covers several register settings, random stalls on both sides, a
// long result back-pressure and quiet drains between phases.
// ----------------------------------------------------------------------------
module mru_tag_cache_with_prefetch_slot_core_tb;

	localparam int SLOTS = mtc_pkg::MAX_ENTRIES_DEF;

	typedef struct {
		bit          func;
		logic [31:0] tag;
	} cache_req_t;

	// same bit order as m_tdata
	typedef struct packed {
		logic       ignored;
		logic       ready_now;
		logic       start_load;
		logic [3:0] slot;
		logic       hit;
	} cache_resp_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] tag
	logic        s_tuser = 1'b0; // [0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [0] hit, [4:1] slot, [5] start_load, [6] ready_now, [7] ignored

	mru_tag_cache_with_prefetch_slot_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run-wide state
	cache_req_t  request_q[$];
	cache_resp_t pending_results[$];
	cache_req_t  cur_req;
	int          err_cnt = 0;
	bit          bursty = 1'b1;
	bit          long_hold_req = 1'b0;
	bit          long_hold_done = 1'b0;
	int          hold_cnt = 0;
	int          src_gap = 0;
	int          sink_gap = 0;

	// list model: order of physical slots, their tags, and the registers
	logic [3:0]  mru_order[SLOTS];
	logic [31:0] mru_tag[SLOTS];
	int          mru_len = 0;
	logic [3:0]  model_extra = '0;
	bit          model_pf = 1'b0;
	logic [31:0] model_inval = '0;

	// one lookup step: cut, search, pick a slot, reinsert
	function automatic cache_resp_t mtf_lookup(input bit func, input logic [31:0] tag);
		cache_resp_t r;
		int          cap;
		int          found;
		int          rm;
		int          ins;
		int          i;
		logic [3:0]  s;
		bit          used[SLOTS];
		r = '0;
		s = '0;
		cap = 1 + int'(model_pf) + int'(model_extra);
		if (cap > SLOTS)
			cap = SLOTS;
		if (mru_len > cap)
			mru_len = cap;
		if (func && !model_pf) begin
			r.ignored = 1'b1;
			return r;
		end
		found = mru_len;
		for (i = 0; i < mru_len; i++) begin
			if (mru_tag[mru_order[i]] == tag) begin
				found = i;
				break;
			end
		end
		rm = -1;
		if (found < mru_len) begin
			s = mru_order[found];
			rm = found;
			r.hit = 1'b1;
		end else begin
			if (mru_len < cap) begin
				for (i = 0; i < SLOTS; i++)
					used[i] = 1'b0;
				for (i = 0; i < mru_len; i++)
					used[mru_order[i]] = 1'b1;
				for (i = SLOTS - 1; i >= 0; i--)
					if (!used[i])
						s = i[3:0];
			end else begin
				s = mru_order[cap - 1];
				rm = cap - 1;
			end
			mru_tag[s] = tag;
			if (tag == model_inval)
				r.ready_now = 1'b1;
			else
				r.start_load = 1'b1;
		end
		// take the entry out of the list
		if (rm >= 0) begin
			for (i = rm; i + 1 < mru_len; i++)
				mru_order[i] = mru_order[i + 1];
			mru_len--;
		end
		// fetch goes to the front, prefetch behind it
		ins = func ? ((mru_len < 1) ? mru_len : 1) : 0;
		for (i = mru_len; i > ins; i--)
			mru_order[i] = mru_order[i - 1];
		mru_order[ins] = s;
		mru_len++;
		r.slot = s;
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		cache_req_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_results.push_back(mtf_lookup(cur_req.func, cur_req.tag));
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (request_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (bursty && $urandom_range(0, 7) == 0) begin
					src_gap <= $urandom_range(0, 2);
					s_tvalid <= 1'b0;
				end else begin
					it = request_q.pop_front();
					cur_req <= it;
					s_tvalid <= 1'b1;
					s_tdata <= it.tag;
					s_tuser <= it.func;
				end
			end
		end
	end

	// result monitor and ready generation
	always @(posedge clk or negedge arst_n) begin
		cache_resp_t want;
		cache_resp_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
			hold_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_results.size() == 0) begin
					$error("result with no request pending: %h", m_tdata);
					err_cnt++;
				end else begin
					want = pending_results.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						err_cnt++;
					end
					if (got.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, got.slot);
						err_cnt++;
					end
					if (got.start_load !== want.start_load) begin
						$error("start_load: expected %0d, got %0d",
							want.start_load, got.start_load);
						err_cnt++;
					end
					if (got.ready_now !== want.ready_now) begin
						$error("ready_now: expected %0d, got %0d",
							want.ready_now, got.ready_now);
						err_cnt++;
					end
					if (got.ignored !== want.ignored) begin
						$error("ignored: expected %0d, got %0d", want.ignored, got.ignored);
						err_cnt++;
					end
				end
			end
			if (long_hold_req && !long_hold_done) begin
				long_hold_done <= 1'b1;
				hold_cnt <= 400;
				m_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (bursty && $urandom_range(0, 7) == 0) begin
				sink_gap <= $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_request(input bit func, input logic [31:0] tag);
		cache_req_t it;
		it.func = func;
		it.tag = tag;
		request_q.push_back(it);
	endtask

	// wait until every request is sent and every result has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_q.size() != 0 || s_tvalid || pending_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// APB write: setup then access, register taken at the access edge
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			mtc_pkg::REG_EXTRA:    model_extra = val[3:0];
			mtc_pkg::REG_PREFETCH: model_pf = val[0];
			mtc_pkg::REG_INVALID:  model_inval = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [3:0] extra, input bit pf, input logic [31:0] inval);
		write_reg(mtc_pkg::REG_EXTRA, {28'd0, extra});
		write_reg(mtc_pkg::REG_PREFETCH, {31'd0, pf});
		write_reg(mtc_pkg::REG_INVALID, inval);
	endtask

	// stimulus sequence
	initial begin
		logic [31:0] pool[$];
		logic [3:0]  extra;
		bit          pf;
		logic [31:0] inval;
		int          pool_size;
		int          pick;
		int          i;
		int          n;
		int          phase;
		bit          func;
		logic [31:0] tag;

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: single entry, no prefetch, invalid tag zero
		push_request(1'b0, 32'h0000_0000);   // invalid tag miss
		push_request(1'b0, 32'h0000_0000);   // hit on invalid tag
		push_request(1'b0, 32'hFFFF_FFFF);   // full list, reuse
		push_request(1'b1, 32'h1234_5678);   // prefetch while disabled
		push_request(1'b0, 32'hFFFF_FFFF);   // hit
		wait_drained();

		// capacity overflow, prefetch on, all-ones invalid tag
		set_config(4'hF, 1'b1, 32'hFFFF_FFFF);
		push_request(1'b1, 32'hFFFF_FFFF);   // prefetch hit on the sole entry
		for (i = 0; i < 17; i++)
			push_request(i[0], {i[3:0], 28'h555_5555} ^ {32{i[1]}});
		push_request(1'b1, 32'hAAAA_AAAA);
		push_request(1'b0, 32'hFFFF_FFFF);
		push_request(1'b0, 32'h5555_5555);
		wait_drained();

		// shrink capacity; the cut happens on the next request
		set_config(4'h0, 1'b1, 32'h0000_0000);
		push_request(1'b0, 32'hAAAA_AAAA);
		push_request(1'b1, 32'h0000_0000);
		wait_drained();

		// random phases over varied settings
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin extra = 4'd0;  pf = 1'b0; inval = 32'h0; end
				1: begin extra = 4'd14; pf = 1'b1; inval = 32'hFFFF_FFFF; end
				2: begin extra = 4'd15; pf = 1'b1; inval = $urandom; end
				3: begin extra = 4'd0;  pf = 1'b1; inval = $urandom; end
				default: begin
					extra = 4'($urandom_range(0, 15));
					pf = $urandom_range(0, 3) != 0;
					inval = $urandom;
				end
			endcase
			set_config(extra, pf, inval);
			if (phase == 7)
				bursty = 1'b0;
			if (phase == 4)
				long_hold_req = 1'b1;

			// a tag pool near the capacity gives both hits and evictions
			pool.delete();
			pool_size = $urandom_range(1, int'(extra) + int'(pf) + 5);
			for (i = 0; i < pool_size; i++)
				pool.push_back($urandom);

			n = 0;
			while (n < 125) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					tag = model_inval;
				else if (pick == 1)
					tag = $urandom;
				else
					tag = pool[$urandom_range(0, pool_size - 1)];
				func = pf ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 9) == 0);
				push_request(func, tag);
				if (!(func && !pf))
					n++;
				// sender pause mid-phase
				if (phase == 5 && n == 60)
					wait_drained();
			end
			wait_drained();
		end

		repeat (60) @(negedge clk);
		if (err_cnt == 0)
			$display("** mru_tag_cache_with_prefetch_slot_core: PASSED **");
		else
			$display("** mru_tag_cache_with_prefetch_slot_core: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 400000);
		$display("** mru_tag_cache_with_prefetch_slot_core: FAILED **");
		$finish;
	end

endmodule
